// File: rtl/ita_pkg.sv
package ita_pkg;

   // Width of the value port; the converted width may be set lower.
   localparam int VALUE_BITS_DEF = 64;
   localparam int VALUE_PORT_W   = 64;
   localparam int CMD_W          = 2;
   localparam int CHAR_W         = 7;
   localparam int DIGIT_W        = 4;

   localparam logic [CMD_W-1:0] CMD_UDEC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SDEC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_OCT  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_HEX  = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

   // Control word from the sequencer to the digit shifter.
   typedef struct packed {
      logic             clear;
      logic             bit_step;
      logic             slot_step;
      logic             bit_in;
      logic [CMD_W-1:0] cmd;
   } ita_ctl_type;

   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
      logic [CHAR_W-1:0] base;
      base = upper ? CHAR_UPPER : CHAR_LOWER;
      if (d <= DIGIT_NINE) begin
         return CHAR_ZERO + CHAR_W'(d);
      end
      return base + CHAR_W'(d - DIGIT_TEN);
   endfunction

endpackage

// File: rtl/integer_to_ascii_radix.sv
// Channel   Ports                                        Direction
// req       req_valid req_stall req_cmd req_upper_case   in  (word: one value)
//           req_value
// rsp       rsp_valid rsp_stall rsp_digit_char rsp_last  out (word: one digit)
//
// One word is converted bit-serially (one bit shifted into the digit slots
// per cycle, with BCD correction in decimal); the sequencer then skips the
// leading zero slots one at a time, ends the scan, emits the digits, holding
// on output stalls, and returns to idle, where the next word is taken.
// Synchronous active-high reset returns the sequencer to idle.
// req_stall is high from acceptance until the last digit is taken; a stalled
// digit holds on rsp_digit_char and rsp_last. A zero value emits no digits.
module integer_to_ascii_radix #(
   parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ita_pkg::CMD_W-1:0]         req_cmd,
   input  logic                              req_upper_case,
   input  logic [ita_pkg::VALUE_PORT_W-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ita_pkg::CHAR_W-1:0]        rsp_digit_char,
   output logic                              rsp_last
);
   import ita_pkg::*;

   // Octal needs the most slots; decimal and hex fit within them.
   localparam int DIGITS = (VALUE_BITS + 2) / 3;
   localparam int BIT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int SLOT_W = $clog2(DIGITS + 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CONVERT = 2'd1;
   localparam logic [1:0] ST_SCAN    = 2'd2;
   localparam logic [1:0] ST_EMIT    = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [BIT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [SLOT_W-1:0]     slot_cnt_ff, slot_cnt_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic                  upper_ff, upper_in;
   logic [VALUE_BITS-1:0] raw_value;
   logic [VALUE_BITS-1:0] magnitude;
   logic [DIGIT_W-1:0]    top_digit;
   ita_ctl_type           ctl;
   logic                  req_take;
   logic                  rsp_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_take  = rsp_valid && !rsp_stall;

   // Drop bits above VALUE_BITS, then take the magnitude in signed mode.
   assign raw_value = req_value[VALUE_BITS-1:0];
   assign magnitude = ((req_cmd == CMD_SDEC) && raw_value[VALUE_BITS-1])
                      ? (~raw_value + VALUE_BITS'(1)) : raw_value;

   always_comb begin
      state_in    = state_ff;
      bit_cnt_in  = bit_cnt_ff;
      slot_cnt_in = slot_cnt_ff;
      value_in    = value_ff;
      cmd_in      = cmd_ff;
      upper_in    = upper_ff;
      ctl.clear     = 1'b0;
      ctl.bit_step  = 1'b0;
      ctl.slot_step = 1'b0;
      ctl.bit_in    = value_ff[VALUE_BITS-1];
      ctl.cmd       = cmd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // Load the word and clear the digit slots.
               value_in   = magnitude;
               cmd_in     = req_cmd;
               upper_in   = req_upper_case;
               bit_cnt_in = BIT_W'(VALUE_BITS - 1);
               ctl.clear  = 1'b1;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // Shift one value bit, most significant first, into the slots.
            ctl.bit_step = 1'b1;
            value_in     = value_ff << 1;
            bit_cnt_in   = bit_cnt_ff - BIT_W'(1);
            if (bit_cnt_ff == '0) begin
               slot_cnt_in = SLOT_W'(DIGITS);
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Skip leading zero slots; a zero value runs out of slots.
            if (slot_cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else if (top_digit == '0) begin
               ctl.slot_step = 1'b1;
               slot_cnt_in   = slot_cnt_ff - SLOT_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Advance one slot per digit taken.
            if (rsp_take) begin
               ctl.slot_step = 1'b1;
               slot_cnt_in   = slot_cnt_ff - SLOT_W'(1);
               if (slot_cnt_ff == SLOT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         bit_cnt_ff  <= '0;
         slot_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         bit_cnt_ff  <= bit_cnt_in;
         slot_cnt_ff <= slot_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      cmd_ff   <= cmd_in;
      upper_ff <= upper_in;
   end

   ita_digit_shifter #(
      .DIGITS (DIGITS)
   ) u_shifter (
      .clock     (clock),
      .ctl       (ctl),
      .top_digit (top_digit)
   );

   // The top slot holds while stalled, so the digit word holds too.
   assign rsp_digit_char = digit_ascii(top_digit, upper_ff);
   assign rsp_last       = (slot_cnt_ff == SLOT_W'(1));

endmodule

// File: rtl/ita_digit_shifter.sv
module ita_digit_shifter #(
   parameter int DIGITS = 22
) (
   input  logic                         clock,
   input  ita_pkg::ita_ctl_type         ctl,
   output logic [ita_pkg::DIGIT_W-1:0]  top_digit
);
   import ita_pkg::*;

   logic [DIGIT_W-1:0] digit_ff [DIGITS];
   logic [DIGIT_W-1:0] digit_in [DIGITS];
   logic [DIGIT_W-1:0] corr     [DIGITS];
   logic               cout     [DIGITS];

   // Each slot shifts left one bit; the carry into a slot comes from the old
   // value of the slot below, so carries do not ripple through the slots.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         corr[i] = digit_ff[i];
         cout[i] = 1'b0;
         unique case (ctl.cmd)
            CMD_UDEC, CMD_SDEC: begin
               if (digit_ff[i] >= 4'd5) begin
                  corr[i] = digit_ff[i] + 4'd3;
               end
               cout[i] = corr[i][3];
            end
            CMD_OCT: begin
               cout[i] = digit_ff[i][2];
            end
            CMD_HEX: begin
               cout[i] = digit_ff[i][3];
            end
            default: begin
               cout[i] = 1'b0;
            end
         endcase
      end
      for (int i = 0; i < DIGITS; i++) begin
         digit_in[i] = digit_ff[i];
         if (ctl.clear) begin
            digit_in[i] = '0;
         end else if (ctl.bit_step) begin
            if (ctl.cmd == CMD_OCT) begin
               digit_in[i] = {1'b0, corr[i][1:0], (i == 0) ? ctl.bit_in : cout[(i+DIGITS-1)%DIGITS]};
            end else begin
               digit_in[i] = {corr[i][2:0], (i == 0) ? ctl.bit_in : cout[(i+DIGITS-1)%DIGITS]};
            end
         end else if (ctl.slot_step) begin
            digit_in[i] = (i == 0) ? '0 : digit_ff[(i+DIGITS-1)%DIGITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIGITS; i++) begin
         digit_ff[i] <= digit_in[i];
      end
   end

   assign top_digit = digit_ff[DIGITS-1];

endmodule

// File: verif/ita_digit_checker.sv
module ita_digit_checker #(
   parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [ita_pkg::CMD_W-1:0]         req_cmd,
   input  logic                              req_upper_case,
   input  logic [ita_pkg::VALUE_PORT_W-1:0]  req_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [ita_pkg::CHAR_W-1:0]        rsp_digit_char,
   input  logic                              rsp_last,
   output int                                mismatch_count,
   output int                                pending_digits
);
   timeunit 1ns;
   timeprecision 1ps;

   import ita_pkg::*;

   localparam int MAX_DIGITS = 22;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_word_type;

   digit_word_type expected_digits[$];

   // Convert one accepted word and queue its digit characters, most significant first.
   function automatic void queue_radix_digits(input logic [CMD_W-1:0] cmd,
                                              input logic upper,
                                              input logic [VALUE_PORT_W-1:0] value);
      logic [VALUE_BITS-1:0]   magnitude;
      logic [VALUE_PORT_W-1:0] quotient;
      logic [VALUE_PORT_W-1:0] radix;
      logic [DIGIT_W-1:0]      slots[MAX_DIGITS];
      logic [CHAR_W-1:0]       wide_digit;
      digit_word_type          entry;
      int                      count;
      magnitude = value[VALUE_BITS-1:0];
      if (cmd == CMD_SDEC && magnitude[VALUE_BITS-1]) begin
         magnitude = -magnitude;
      end
      if (cmd == CMD_OCT) begin
         radix = VALUE_PORT_W'(8);
      end else if (cmd == CMD_HEX) begin
         radix = VALUE_PORT_W'(16);
      end else begin
         radix = VALUE_PORT_W'(10);
      end
      quotient = '0;
      quotient[VALUE_BITS-1:0] = magnitude;
      count = 0;
      while (quotient != 0 && count < MAX_DIGITS) begin
         slots[count] = DIGIT_W'(quotient % radix);
         quotient = quotient / radix;
         count++;
      end
      for (int k = count - 1; k >= 0; k--) begin
         wide_digit = '0;
         wide_digit[DIGIT_W-1:0] = slots[k];
         if (slots[k] <= DIGIT_NINE) begin
            entry.digit_char = CHAR_ZERO + wide_digit;
         end else begin
            entry.digit_char = (upper ? CHAR_UPPER : CHAR_LOWER) + wide_digit - CHAR_W'(10);
         end
         entry.last = (k == 0);
         expected_digits.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      digit_word_type want;
      if (reset) begin
         expected_digits.delete();
         mismatch_count = 0;
      end else begin
         // Check the outgoing digit before queuing a new word's digits.
         if (rsp_valid && !rsp_stall) begin
            if (expected_digits.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("unexpected digit: char %h last %b", rsp_digit_char, rsp_last);
               end
               mismatch_count++;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_digit_char !== want.digit_char || rsp_last !== want.last) begin
                  if (mismatch_count < 10) begin
                     $display("digit mismatch: expected char %h last %b, got char %h last %b",
                              want.digit_char, want.last, rsp_digit_char, rsp_last);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            queue_radix_digits(req_cmd, req_upper_case, req_value);
         end
      end
      pending_digits = expected_digits.size();
   end

endmodule

// File: verif/tb_integer_to_ascii_radix.sv
module tb_integer_to_ascii_radix;
   timeunit 1ns;
   timeprecision 1ps;

   import ita_pkg::*;

   // Watchdog limit, set well above the slowest legal run.
   localparam int CYCLE_LIMIT   = 400000;
   // A zero word emits nothing but still runs.
   localparam int TAIL_CYCLES   = 120;
   localparam int RANDOM_WORDS  = 150;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_cmd;
   logic                      req_upper_case;
   logic [VALUE_PORT_W-1:0]   req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [CHAR_W-1:0]         rsp_digit_char;
   logic                      rsp_last;

   int            mismatch_count;
   int            pending_digits;
   int            cycle_count;
   idle_mode_type idle_mode;

   integer_to_ascii_radix dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_upper_case (req_upper_case),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   // Watch both channels, predict every digit and count mismatches.
   ita_digit_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_upper_case (req_upper_case),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .pending_digits (pending_digits)
   );

   // 20 ns clock: low half first, then high.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Receiver side: stall the digit channel at random according to the current phase.
   always @(negedge clock) begin
      case (idle_mode)
         IDLE_RECEIVER: begin
            rsp_stall <= ($urandom_range(99) < 84);
         end
         IDLE_BOTH: begin
            rsp_stall <= ($urandom_range(99) < 28);
         end
         default: begin
            rsp_stall <= 1'b0;
         end
      endcase
   end

   // Watchdog: end the run as failed if it overstays the cycle limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_integer_to_ascii_radix failed");
      $finish;
   end

   // Present one word and hold it until accepted. Called and returning at a falling edge.
   // Valid is lowered only when an idle gap precedes the word, so back-to-back words
   // keep valid high without a second assignment in the same step.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic upper,
                            input logic [VALUE_PORT_W-1:0] value);
      int gap;
      int gap_pct;
      gap = 0;
      gap_pct = (idle_mode == IDLE_SENDER) ? 84 : (idle_mode == IDLE_BOTH) ? 28 : 0;
      while ($urandom_range(99) < gap_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_upper_case <= upper;
      req_value      <= value;
      // Hold the word until an edge sees it with no stall.
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Drop valid and wait for every predicted digit to come out.
   task automatic drain_digits();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_digits != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      logic [CMD_W-1:0]        cmd;
      logic [VALUE_PORT_W-1:0] value;
      int                      shape;

      // Drive every input to a known value from time zero.
      idle_mode      = IDLE_NONE;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_UDEC;
      req_upper_case = 1'b0;
      req_value      = '0;
      rsp_stall      = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words: field extremes, every mode and the corner cases.
      send_word(CMD_UDEC, 1'b0, 64'd0);                    // zero emits nothing
      send_word(CMD_UDEC, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);  // 20 decimal digits
      send_word(CMD_UDEC, 1'b1, 64'd1);                    // upper case ignored
      send_word(CMD_UDEC, 1'b0, 64'd10);
      send_word(CMD_UDEC, 1'b0, 64'd9);
      send_word(CMD_SDEC, 1'b0, 64'h8000_0000_0000_0000);  // most negative: -2^63
      send_word(CMD_SDEC, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);  // minus one
      send_word(CMD_SDEC, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
      send_word(CMD_SDEC, 1'b0, 64'd0);
      send_word(CMD_SDEC, 1'b0, 64'd5);
      send_word(CMD_OCT,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF);  // 22 octal digits
      send_word(CMD_OCT,  1'b1, 64'h8000_0000_0000_0000);
      send_word(CMD_OCT,  1'b0, 64'd8);
      send_word(CMD_OCT,  1'b0, 64'd7);
      send_word(CMD_HEX,  1'b0, 64'hFEDC_BA98_7654_3210);
      send_word(CMD_HEX,  1'b1, 64'hFEDC_BA98_7654_3210);
      send_word(CMD_HEX,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(CMD_HEX,  1'b1, 64'd10);
      send_word(CMD_HEX,  1'b0, 64'h0000_0000_00AB_CDEF);
      send_word(CMD_HEX,  1'b0, 64'd0);

      // Pause the sender until all predicted digits have arrived.
      drain_digits();

      // Random words in four idling phases, draining between phases.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % (RANDOM_WORDS / 4 + 1) == 0 && i != 0) begin
            drain_digits();
         end
         idle_mode = idle_mode_type'((i / (RANDOM_WORDS / 4 + 1)) % 4);
         cmd = CMD_W'($urandom_range(3));
         // Vary the digit count: mostly random values of random length,
         // plus zeros, all ones, single bits and negated random values.
         shape = $urandom_range(9);
         case (shape)
            0: value = '0;
            1: value = '1;
            2: value = 64'd1 << $urandom_range(63);
            3: value = -({$urandom, $urandom} >> $urandom_range(63));
            default: value = {$urandom, $urandom} >> $urandom_range(63);
         endcase
         send_word(cmd, 1'($urandom_range(1)), value);
      end

      drain_digits();
      idle_mode = IDLE_NONE;
      // Allow a trailing zero word to finish and any stray digit to show up.
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && pending_digits == 0) begin
         $display("tb_integer_to_ascii_radix passed");
      end else begin
         $display("tb_integer_to_ascii_radix failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/ita_pkg.sv
rtl/ita_digit_shifter.sv
rtl/integer_to_ascii_radix.sv
verif/ita_digit_checker.sv
verif/tb_integer_to_ascii_radix.sv
